### rtl/first_sunday_of_month_via_easter_assert.svh
// ----------------------------------------------------------------------------
// assertion macros used by the checker file
// ----------------------------------------------------------------------------
`ifndef FIRST_SUNDAY_OF_MONTH_VIA_EASTER_ASSERT_SVH
`define FIRST_SUNDAY_OF_MONTH_VIA_EASTER_ASSERT_SVH

// same-cycle implication, checked outside reset
`define FSME_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("implication check failed");

// implication with the consequent delayed by n, checked outside reset
`define FSME_ASSERT_DELAY(label, clk, rst_n, ante, n, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> ##(n) (cons)) \
        else $error("delayed implication check failed");

`endif

### rtl/fsme_pkg.sv
// ----------------------------------------------------------------------------
// fsme_pkg
// types, constants and tables for the first-sunday-via-easter pipeline
// ----------------------------------------------------------------------------
package fsme_pkg;

    localparam int YEAR_W  = 14;
    localparam int MONTH_W = 4;

    localparam logic [YEAR_W-1:0] YEAR_MIN = 14'd1583;
    localparam logic [YEAR_W-1:0] YEAR_MAX = 14'd9999;

    localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd1;
    localparam logic [MONTH_W-1:0] MONTH_FEB = 4'd2;
    localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd12;

    // reciprocal multipliers for division by constants
    localparam logic [15:0] RECIP_19  = 16'd55189; // /19, shift 20
    localparam logic [13:0] RECIP_100 = 14'd10486; // /100, shift 20
    localparam logic [5:0]  RECIP_25  = 6'd41;     // /25, shift 10
    localparam logic [7:0]  RECIP_3   = 8'd171;    // /3, shift 9
    localparam logic [11:0] RECIP_30  = 12'd2185;  // /30, shift 16
    localparam logic [7:0]  RECIP_7S  = 8'd147;    // /7 for small values, shift 10
    localparam logic [9:0]  RECIP_7D  = 10'd586;   // /7 for day offsets, shift 12

    // stages inside the easter part and in total
    localparam int EASTER_STAGES = 9;
    localparam int LATENCY       = 12;

    // easter result with the side band of the query
    typedef struct packed {
        logic               valid;
        logic [4:0]         day;
        logic [2:0]         month;
        logic               leap;
        logic               oor;
        logic [MONTH_W-1:0] mon;
    } t_easter;

    // days before the first of a month in a common year
    function automatic logic [8:0] days_before(input logic [MONTH_W-1:0] mon);
        logic [8:0] v;
        case (mon)
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd0;
        endcase
        return v;
    endfunction

    // days in a month of a common year
    function automatic logic [4:0] month_days(input logic [MONTH_W-1:0] mon);
        logic [4:0] v;
        case (mon)
            4'd2:    v = 5'd28;
            4'd4:    v = 5'd30;
            4'd6:    v = 5'd30;
            4'd9:    v = 5'd30;
            4'd11:   v = 5'd30;
            default: v = 5'd31;
        endcase
        return v;
    endfunction

endpackage

### rtl/fsme_easter.sv
// ----------------------------------------------------------------------------
// fsme_easter
// nine-stage computus pipeline: easter date, leap flag and range flag
// ----------------------------------------------------------------------------
module fsme_easter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic [fsme_pkg::YEAR_W-1:0]  i_year,
    input  logic [fsme_pkg::MONTH_W-1:0] i_month,
    output fsme_pkg::t_easter            o_res
);

    // valid bits, one per stage
    logic [fsme_pkg::EASTER_STAGES-1:0] r_vld;
    logic [fsme_pkg::EASTER_STAGES-1:0] n_vld;

    assign n_vld = {r_vld[fsme_pkg::EASTER_STAGES-2:0], i_valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // ---------------- stage 1: quotients by 19 and 100, month clamp, range flag
    logic [29:0] w1_p19;
    logic [27:0] w1_p100;
    logic [fsme_pkg::MONTH_W-1:0] n1_mon;
    logic        n1_oor;
    logic [fsme_pkg::YEAR_W-1:0]  r1_year;
    logic [fsme_pkg::MONTH_W-1:0] r1_mon;
    logic        r1_oor;
    logic [9:0]  r1_q19;
    logic [7:0]  r1_b;

    assign w1_p19  = 30'(i_year) * 30'(fsme_pkg::RECIP_19);
    assign w1_p100 = 28'(i_year) * 28'(fsme_pkg::RECIP_100);
    assign n1_oor  = (i_year < fsme_pkg::YEAR_MIN) || (i_year > fsme_pkg::YEAR_MAX);

    always_comb begin
        n1_mon = i_month;
        if (i_month < fsme_pkg::MONTH_JAN) begin
            n1_mon = fsme_pkg::MONTH_JAN;
        end else if (i_month > fsme_pkg::MONTH_DEC) begin
            n1_mon = fsme_pkg::MONTH_DEC;
        end
    end

    always_ff @(posedge i_clk) begin
        r1_year <= i_year;
        r1_mon  <= n1_mon;
        r1_oor  <= n1_oor;
        r1_q19  <= w1_p19[29:20];
        r1_b    <= w1_p100[27:20];
    end

    // ---------------- stage 2: remainders, f term, leap rule
    logic [13:0] w2_a_full;
    logic [13:0] w2_c_full;
    logic [12:0] w2_fp;
    logic [4:0]  n2_a;
    logic [6:0]  n2_c;
    logic        n2_leap;
    logic [4:0]  r2_a;
    logic [7:0]  r2_b;
    logic [6:0]  r2_c;
    logic [2:0]  r2_f;
    logic        r2_leap;
    logic [fsme_pkg::MONTH_W-1:0] r2_mon;
    logic        r2_oor;

    assign w2_a_full = r1_year - 14'(14'(r1_q19) * 14'd19);
    assign w2_c_full = r1_year - 14'(14'(r1_b) * 14'd100);
    assign n2_a      = w2_a_full[4:0];
    assign n2_c      = w2_c_full[6:0];
    assign w2_fp     = 13'(8'(r1_b + 8'd8)) * 13'(fsme_pkg::RECIP_25);
    // divisible by 4, and not by 100 unless by 400
    assign n2_leap   = (r1_year[1:0] == 2'd0) && ((n2_c != 7'd0) || (r1_b[1:0] == 2'd0));

    always_ff @(posedge i_clk) begin
        r2_a    <= n2_a;
        r2_b    <= r1_b;
        r2_c    <= n2_c;
        r2_f    <= w2_fp[12:10];
        r2_leap <= n2_leap;
        r2_mon  <= r1_mon;
        r2_oor  <= r1_oor;
    end

    // ---------------- stage 3: g term and the sum ahead of the mod 30
    logic [7:0]  w3_gx;
    logic [14:0] w3_gp;
    logic [5:0]  w3_g;
    logic [11:0] n3_t;
    logic [11:0] r3_t;
    logic [4:0]  r3_a;
    logic [1:0]  r3_e;
    logic [4:0]  r3_i;
    logic [1:0]  r3_k;
    logic        r3_leap;
    logic [fsme_pkg::MONTH_W-1:0] r3_mon;
    logic        r3_oor;

    assign w3_gx = r2_b - 8'(r2_f) + 8'd1;
    assign w3_gp = 15'(w3_gx) * 15'(fsme_pkg::RECIP_3);
    assign w3_g  = w3_gp[14:9];
    assign n3_t  = 12'(12'(r2_a) * 12'd19) + 12'(r2_b) + 12'd1815
                 - 12'(r2_b[7:2]) - 12'(w3_g);

    always_ff @(posedge i_clk) begin
        r3_t    <= n3_t;
        r3_a    <= r2_a;
        r3_e    <= r2_b[1:0];
        r3_i    <= r2_c[6:2];
        r3_k    <= r2_c[1:0];
        r3_leap <= r2_leap;
        r3_mon  <= r2_mon;
        r3_oor  <= r2_oor;
    end

    // ---------------- stage 4: quotient by 30
    logic [22:0] w4_p30;
    logic [6:0]  r4_q30;
    logic [11:0] r4_t;
    logic [4:0]  r4_a;
    logic [1:0]  r4_e;
    logic [4:0]  r4_i;
    logic [1:0]  r4_k;
    logic        r4_leap;
    logic [fsme_pkg::MONTH_W-1:0] r4_mon;
    logic        r4_oor;

    assign w4_p30 = 23'(r3_t) * 23'(fsme_pkg::RECIP_30);

    always_ff @(posedge i_clk) begin
        r4_q30  <= w4_p30[22:16];
        r4_t    <= r3_t;
        r4_a    <= r3_a;
        r4_e    <= r3_e;
        r4_i    <= r3_i;
        r4_k    <= r3_k;
        r4_leap <= r3_leap;
        r4_mon  <= r3_mon;
        r4_oor  <= r3_oor;
    end

    // ---------------- stage 5: h, and the sum ahead of the mod 7
    logic [11:0] w5_h_full;
    logic [4:0]  n5_h;
    logic [7:0]  n5_l_sum;
    logic [4:0]  r5_h;
    logic [7:0]  r5_l_sum;
    logic [4:0]  r5_a;
    logic        r5_leap;
    logic [fsme_pkg::MONTH_W-1:0] r5_mon;
    logic        r5_oor;

    assign w5_h_full = r4_t - 12'(12'(r4_q30) * 12'd30);
    assign n5_h      = w5_h_full[4:0];
    assign n5_l_sum  = 8'd102 + 8'({r4_e, 1'b0}) + 8'({r4_i, 1'b0})
                     - 8'(n5_h) - 8'(r4_k);

    always_ff @(posedge i_clk) begin
        r5_h     <= n5_h;
        r5_l_sum <= n5_l_sum;
        r5_a     <= r4_a;
        r5_leap  <= r4_leap;
        r5_mon   <= r4_mon;
        r5_oor   <= r4_oor;
    end

    // ---------------- stage 6: quotient by 7
    logic [14:0] w6_p7;
    logic [4:0]  r6_q7;
    logic [7:0]  r6_l_sum;
    logic [4:0]  r6_h;
    logic [4:0]  r6_a;
    logic        r6_leap;
    logic [fsme_pkg::MONTH_W-1:0] r6_mon;
    logic        r6_oor;

    assign w6_p7 = 15'(r5_l_sum) * 15'(fsme_pkg::RECIP_7S);

    always_ff @(posedge i_clk) begin
        r6_q7    <= w6_p7[14:10];
        r6_l_sum <= r5_l_sum;
        r6_h     <= r5_h;
        r6_a     <= r5_a;
        r6_leap  <= r5_leap;
        r6_mon   <= r5_mon;
        r6_oor   <= r5_oor;
    end

    // ---------------- stage 7: l
    logic [7:0]  w7_l_full;
    logic [2:0]  r7_l;
    logic [4:0]  r7_h;
    logic [4:0]  r7_a;
    logic        r7_leap;
    logic [fsme_pkg::MONTH_W-1:0] r7_mon;
    logic        r7_oor;

    assign w7_l_full = r6_l_sum - 8'(8'(r6_q7) * 8'd7);

    always_ff @(posedge i_clk) begin
        r7_l    <= w7_l_full[2:0];
        r7_h    <= r6_h;
        r7_a    <= r6_a;
        r7_leap <= r6_leap;
        r7_mon  <= r6_mon;
        r7_oor  <= r6_oor;
    end

    // ---------------- stage 8: m correction and the offset day count that stage 9 splits
    logic [8:0]  w8_msum;
    logic        w8_m;
    logic [7:0]  n8_base;
    logic [7:0]  r8_base;
    logic        r8_leap;
    logic [fsme_pkg::MONTH_W-1:0] r8_mon;
    logic        r8_oor;

    assign w8_msum = 9'(r7_a) + 9'(9'(r7_h) * 9'd11) + 9'(9'(r7_l) * 9'd22);
    assign w8_m    = (w8_msum >= 9'd451);
    assign n8_base = 8'(r7_h) + 8'(r7_l) + 8'd114 - (w8_m ? 8'd7 : 8'd0);

    always_ff @(posedge i_clk) begin
        r8_base <= n8_base;
        r8_leap <= r7_leap;
        r8_mon  <= r7_mon;
        r8_oor  <= r7_oor;
    end

    // ---------------- stage 9: split into month and day
    logic       w9_april;
    logic [7:0] w9_day_full;
    logic [4:0] r9_day;
    logic [2:0] r9_month;
    logic       r9_leap;
    logic       r9_oor;
    logic [fsme_pkg::MONTH_W-1:0] r9_mon;

    // the count never reaches five months, so one compare picks the month
    assign w9_april    = (r8_base >= 8'd124);
    assign w9_day_full = r8_base - (w9_april ? 8'd123 : 8'd92);

    always_ff @(posedge i_clk) begin
        r9_day   <= w9_day_full[4:0];
        r9_month <= w9_april ? 3'd4 : 3'd3;
        r9_leap  <= r8_leap;
        r9_oor   <= r8_oor;
        r9_mon   <= r8_mon;
    end

    always_comb begin
        o_res.valid = r_vld[fsme_pkg::EASTER_STAGES-1];
        o_res.day   = r9_day;
        o_res.month = r9_month;
        o_res.leap  = r9_leap;
        o_res.oor   = r9_oor;
        o_res.mon   = r9_mon;
    end

endmodule

### rtl/first_sunday_of_month_via_easter.sv
// o_strobe follows the start transfer through the computus stages and the tail stages
// throughput: one query per cycle, busy stays low, no stall on either side
// the computus pipeline sets most of the depth, with the constant divisions as reciprocal multiplies
// reset: synchronous, active low, clears every stage valid bit; data is not reset
// results appear for exactly one cycle and cannot be held off by the receiver
// ----------------------------------------------------------------------------
// first_sunday_of_month_via_easter
// easter date, month length and the first sunday of a month, fully pipelined
// ----------------------------------------------------------------------------
module first_sunday_of_month_via_easter (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         start,
    output logic                         busy,
    input  logic [fsme_pkg::YEAR_W-1:0]  i_year,
    input  logic [fsme_pkg::MONTH_W-1:0] i_month,
    output logic                         o_strobe,
    output logic [2:0]                   o_sunday_date,
    output logic [4:0]                   o_days_in_month,
    output logic [4:0]                   o_feast_day,
    output logic [2:0]                   o_feast_month,
    output logic                         o_out_of_range
);

    // every cycle takes a new query
    logic w_accept;

    assign busy     = 1'b0;
    assign w_accept = start && !busy;

    // computus stages
    fsme_pkg::t_easter w_easter;

    fsme_easter u_easter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_year  (i_year),
        .i_month (i_month),
        .o_res   (w_easter)
    );

    // valid bits of the three tail stages
    logic [2:0] r_vld;
    logic [2:0] n_vld;

    assign n_vld = {r_vld[1:0], w_easter.valid};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    // stage 10: day distance from the first of the month to easter, plus a week multiple
    logic [8:0] w10_eord;
    logic [8:0] w10_ford;
    logic [9:0] n10_dist;
    logic [4:0] n10_len;
    logic [9:0] r10_dist;
    logic [4:0] r10_len;
    logic [4:0] r10_eday;
    logic [2:0] r10_emon;
    logic       r10_oor;

    assign w10_eord = fsme_pkg::days_before(4'(w_easter.month)) + 9'(w_easter.leap)
                    + 9'(w_easter.day) - 9'd1;
    assign w10_ford = fsme_pkg::days_before(w_easter.mon)
                    + 9'(w_easter.leap && (w_easter.mon > fsme_pkg::MONTH_FEB));
    assign n10_dist = 10'(w10_eord) + 10'd420 - 10'(w10_ford);

    always_comb begin
        n10_len = fsme_pkg::month_days(w_easter.mon);
        if ((w_easter.mon == fsme_pkg::MONTH_FEB) && w_easter.leap) begin
            n10_len = 5'd29;
        end
    end

    always_ff @(posedge i_clk) begin
        r10_dist <= n10_dist;
        r10_len  <= n10_len;
        r10_eday <= w_easter.day;
        r10_emon <= w_easter.month;
        r10_oor  <= w_easter.oor;
    end

    // stage 11: weeks in the distance
    logic [18:0] w11_prod;
    logic [6:0]  r11_weeks;
    logic [9:0]  r11_dist;
    logic [4:0]  r11_len;
    logic [4:0]  r11_eday;
    logic [2:0]  r11_emon;
    logic        r11_oor;

    assign w11_prod = 19'(r10_dist) * 19'(fsme_pkg::RECIP_7D);

    always_ff @(posedge i_clk) begin
        r11_weeks <= w11_prod[18:12];
        r11_dist  <= r10_dist;
        r11_len   <= r10_len;
        r11_eday  <= r10_eday;
        r11_emon  <= r10_emon;
        r11_oor   <= r10_oor;
    end

    // stage 12: remainder gives the first sunday, 1 to 7
    logic [9:0] w12_rem;
    logic [2:0] n12_fs;
    logic [2:0] r_sunday_date;
    logic [4:0] r_days_in_month;
    logic [4:0] r_feast_day;
    logic [2:0] r_feast_month;
    logic       r_out_of_range;

    assign w12_rem = r11_dist - 10'(10'(r11_weeks) * 10'd7);
    assign n12_fs  = w12_rem[2:0] + 3'd1;

    always_ff @(posedge i_clk) begin
        r_sunday_date   <= n12_fs;
        r_days_in_month <= r11_len;
        r_feast_day     <= r11_eday;
        r_feast_month   <= r11_emon;
        r_out_of_range  <= r11_oor;
    end

    // result ports
    assign o_strobe        = r_vld[2];
    assign o_sunday_date   = r_sunday_date;
    assign o_days_in_month = r_days_in_month;
    assign o_feast_day     = r_feast_day;
    assign o_feast_month   = r_feast_month;
    assign o_out_of_range  = r_out_of_range;

endmodule

### rtl/fsme_checker.sv
// ----------------------------------------------------------------------------
// fsme_checker
// port-level checks on latency and result plausibility, bound to the top level
// ----------------------------------------------------------------------------
`include "first_sunday_of_month_via_easter_assert.svh"

module fsme_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       start,
    input logic       busy,
    input logic       o_strobe,
    input logic [2:0] o_sunday_date,
    input logic [4:0] o_days_in_month,
    input logic [4:0] o_feast_day,
    input logic [2:0] o_feast_month,
    input logic       o_out_of_range
);

    logic w_accept;
    logic w_month_ok;
    logic w_window_ok;

    assign w_accept    = start && !busy;
    assign w_month_ok  = (o_sunday_date != 3'd0) && (o_days_in_month >= 5'd28)
                       && (o_days_in_month <= 5'd31);
    assign w_window_ok = ((o_feast_month == 3'd3) && (o_feast_day >= 5'd22))
                       || ((o_feast_month == 3'd4) && (o_feast_day <= 5'd25));

    // every accepted query yields its result after the package LATENCY
    `FSME_ASSERT_DELAY(a_result_follows, i_clk, i_rst_n, w_accept, fsme_pkg::LATENCY, o_strobe)

    // no result without a query one latency earlier
    `FSME_ASSERT_IMPLY(a_no_spurious, i_clk, i_rst_n, o_strobe, $past(w_accept, fsme_pkg::LATENCY))

    // first sunday and month length stay in their calendar ranges
    `FSME_ASSERT_IMPLY(a_month_fields, i_clk, i_rst_n, o_strobe, w_month_ok)

    // easter falls between 22 march and 25 april for valid years
    `FSME_ASSERT_IMPLY(a_easter_window, i_clk, i_rst_n, o_strobe && !o_out_of_range, w_window_ok)

endmodule

bind first_sunday_of_month_via_easter fsme_checker u_fsme_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .start           (start),
    .busy            (busy),
    .o_strobe        (o_strobe),
    .o_sunday_date   (o_sunday_date),
    .o_days_in_month (o_days_in_month),
    .o_feast_day     (o_feast_day),
    .o_feast_month   (o_feast_month),
    .o_out_of_range  (o_out_of_range)
);
